// ===== rtl/rmf_pkg.sv =====
// Shared types, constants and a helper function for the running median filter.
package rmf_pkg;

  localparam int MAX_WINDOW   = 31;
  localparam int WINDOW_RESET = 9;
  localparam int SAMPLE_W     = 16;
  localparam int LEN_W        = 5;
  localparam int IDX_W        = $clog2(MAX_WINDOW);
  localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
  localparam int APB_AW       = 2;
  localparam int APB_DW       = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [CNT_W-1:0]           len_t;
  typedef logic [LEN_W-1:0]           wlen_t;

  typedef enum logic [APB_AW-1:0] {
    REG_WINDOW_LENGTH = 2'd0
  } reg_addr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    step;
    sample_t cand;
    idx_t    cand_idx;
    idx_t    half;
    len_t    len;
  } cell_ctrl_t;

  function automatic len_t eff_len(wlen_t w);
    len_t n;
    if (int'(w) > MAX_WINDOW) begin
      n = CNT_W'(MAX_WINDOW);
    end else begin
      n = CNT_W'(w);
    end
    if (n[0] == 1'b0) begin
      n = (n == '0) ? CNT_W'(1) : n - CNT_W'(1);
    end
    return n;
  endfunction

endpackage

// ===== rtl/rmf_if.sv =====
// Valid/ready stream interfaces for the sample and median channels.
interface rmf_sample_if import rmf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmf_median_if import rmf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t median;
  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

// ===== rtl/rmf_cell.sv =====
// One window cell: holds a sample, a circulating copy and its rank count.
module rmf_cell import rmf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  idx_t       idx,
  input  sample_t    v_in,
  input  sample_t    c_in,
  output sample_t    v_out,
  output sample_t    c_out,
  output logic       sel
);

  sample_t v_r, v_nxt;
  sample_t c_r, c_nxt;
  idx_t    cnt_r, cnt_nxt;
  logic    ranks_below;

  assign ranks_below = (ctrl.cand < v_r) || ((ctrl.cand == v_r) && (ctrl.cand_idx < idx));

  always_comb begin
    v_nxt   = v_r;
    c_nxt   = c_r;
    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      v_nxt   = v_in;
      c_nxt   = v_in;
      cnt_nxt = '0;
    end else if (ctrl.step) begin
      c_nxt = c_in;
      if (ranks_below) begin
        cnt_nxt = cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      cnt_r <= '0;
    end else begin
      v_r   <= v_nxt;
      cnt_r <= cnt_nxt;
    end
    c_r <= c_nxt;
  end

  assign v_out = v_r;
  assign c_out = c_r;
  assign sel   = (cnt_r == ctrl.half) && (CNT_W'(idx) < ctrl.len);

endmodule

// ===== rtl/rmf_apb_regs.sv =====
// APB-style configuration register file holding the window length.
module rmf_apb_regs import rmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output wlen_t             window_length
);

  wlen_t wlen_r, wlen_nxt;
  logic  wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == REG_WINDOW_LENGTH);

  always_comb begin
    wlen_nxt = wlen_r;
    if (wr_en) begin
      wlen_nxt = cfg_pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= LEN_W'(WINDOW_RESET);
    end else begin
      wlen_r <= wlen_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_WINDOW_LENGTH: cfg_prdata = APB_DW'(wlen_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign window_length = wlen_r;

endmodule

// ===== rtl/running_median_filter_core.sv =====
// Running median filter top level: cell chain, sequencer and output register.
// The rank count steps one stored sample through the cell chain per cycle; a new request
// is taken only after the previous median has been loaded into the output register.
// The output register lets the next request enter while a median waits to be taken.
// Synchronous active-low reset clears the window to zeros and sets the length to 9.
module running_median_filter_core import rmf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rmf_sample_if.sink        in_s,
  rmf_median_if.source      out_m,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  state_t     state_r, state_nxt;
  idx_t       j_r, j_nxt;
  logic       out_valid_r, out_valid_nxt;
  sample_t    median_r, median_nxt;
  wlen_t      window_length;
  len_t       n_eff;
  logic       accept, step, out_load;
  cell_ctrl_t ctrl;
  sample_t    v_vec [MAX_WINDOW];
  sample_t    c_vec [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] sel_vec;
  sample_t    picked;

  rmf_apb_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .window_length (window_length)
  );

  assign n_eff  = eff_len(window_length);
  assign accept = in_s.valid && in_s.ready;

  assign ctrl.load     = accept;
  assign ctrl.step     = step;
  assign ctrl.cand     = c_vec[0];
  assign ctrl.cand_idx = j_r;
  assign ctrl.half     = IDX_W'(n_eff >> 1);
  assign ctrl.len      = n_eff;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    sample_t v_in, c_in;
    if (i == 0) begin : g_head
      assign v_in = in_s.sample;
    end else begin : g_body
      assign v_in = v_vec[i-1];
    end
    if (i == MAX_WINDOW - 1) begin : g_tail
      assign c_in = c_vec[i];
    end else begin : g_mid
      assign c_in = c_vec[i+1];
    end
    rmf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .idx   (IDX_W'(i)),
      .v_in  (v_in),
      .c_in  (c_in),
      .v_out (v_vec[i]),
      .c_out (c_vec[i]),
      .sel   (sel_vec[i])
    );
  end

  always_comb begin
    picked = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (sel_vec[i]) begin
        picked = picked | v_vec[i];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_s.valid) begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (CNT_W'(j_r) == n_eff - CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_m.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_s.ready = 1'b0;
    step       = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE:  in_s.ready = 1'b1;
      ST_COUNT: step = 1'b1;
      ST_EMIT:  out_load = !out_valid_r || out_m.ready;
      default: begin
        in_s.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    j_nxt = j_r;
    if (accept) begin
      j_nxt = '0;
    end else if (step) begin
      j_nxt = j_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    median_nxt    = median_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      median_nxt    = picked;
    end else if (out_m.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
    median_r <= median_nxt;
  end

  assign out_m.valid  = out_valid_r;
  assign out_m.median = median_r;

  a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> $onehot(sel_vec))
    else $error("median select is not one-hot");

  a_count_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_COUNT) && (j_r == '0))
    else $error("rank count did not start after a request");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COUNT) |-> (CNT_W'(j_r) < n_eff))
    else $error("rank count ran past the window");

  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && out_load) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("median not presented after emit");

endmodule
